// File: src/afsm_pkg.sv
// ----------------------------------------------------------------------------
// afsm_pkg: shared types and codes for the affix family subsequence matcher
// Request and result payloads, operation and register codes, read controls.
// ----------------------------------------------------------------------------
package afsm_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;
    localparam int RES_COUNT_W = 16;
    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [OP_W-1:0] OP_PREFIX = 2'd0;
    localparam logic [OP_W-1:0] OP_SUFFIX = 2'd1;
    localparam logic [OP_W-1:0] OP_WORD   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_CHAR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUFFIX_LENGTH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  table_index;
        logic [CHAR_W-1:0] char_value;
        logic              word_last;
    } item_t;

    typedef struct packed {
        logic                   matched;
        logic [RES_COUNT_W-1:0] middle_count;
    } result_t;

    typedef struct packed {
        logic rd_prefix;
        logic rd_suffix;
    } rd_ctrl_t;

endpackage

// File: src/afsm_ram.sv
// ----------------------------------------------------------------------------
// afsm_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data appears the cycle after rd_en.
// ----------------------------------------------------------------------------
module afsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/afsm_walk.sv
// ----------------------------------------------------------------------------
// afsm_walk: pattern walk sequencer for one word character
// Steps through prefix and suffix tables with one shared compare, tracks the
// middle repeat count and the fail state, and emits the result on the last char.
// ----------------------------------------------------------------------------
module afsm_walk
    import afsm_pkg::*;
#(
    parameter int AFFIX_DEPTH = 64,
    parameter int COUNT_WIDTH = 16,
    parameter int ADDR_W      = (AFFIX_DEPTH > 1) ? $clog2(AFFIX_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              last_in,
    input  logic [CHAR_W-1:0] middle_char,
    input  logic [LEN_W-1:0]  prefix_length,
    input  logic [LEN_W-1:0]  suffix_length,
    output rd_ctrl_t          rd,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [CHAR_W-1:0] prefix_rdata,
    input  logic [CHAR_W-1:0] suffix_rdata,
    input  logic              slot_free,
    output logic              ready,
    output logic              res_load,
    output result_t           res
);

    localparam int POS_W     = $clog2(AFFIX_DEPTH + 1);
    localparam int LEN_EXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int CNT_EXT_W = (COUNT_WIDTH > RES_COUNT_W) ? COUNT_WIDTH : RES_COUNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_CMP_P = 3'd2;
    localparam logic [2:0] ST_CMP_S = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic [POS_W-1:0]       prefix_pos_reg, prefix_pos_next;
    logic [POS_W-1:0]       suffix_pos_reg, suffix_pos_next;
    logic                   mid_done_reg, mid_done_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   fail_reg, fail_next;

    logic [LEN_EXT_W-1:0]   depth_ext;
    logic [LEN_EXT_W-1:0]   plen;
    logic [LEN_EXT_W-1:0]   slen;
    logic                   pre_more;
    logic                   suf_more;
    logic [CHAR_W-1:0]      cmp_data;
    logic                   cmp_hit;
    logic [CNT_EXT_W-1:0]   count_ext;

    // clip the length registers to the table depth
    assign depth_ext = LEN_EXT_W'(AFFIX_DEPTH);
    assign plen = (LEN_EXT_W'(prefix_length) > depth_ext) ? depth_ext
                                                          : LEN_EXT_W'(prefix_length);
    assign slen = (LEN_EXT_W'(suffix_length) > depth_ext) ? depth_ext
                                                          : LEN_EXT_W'(suffix_length);
    assign pre_more = LEN_EXT_W'(prefix_pos_reg) < plen;
    assign suf_more = LEN_EXT_W'(suffix_pos_reg) < slen;

    // shared compare against whichever table was read last cycle
    assign cmp_data = (state_reg == ST_CMP_S) ? suffix_rdata : prefix_rdata;
    assign cmp_hit  = (cmp_data == char_reg);

    always_comb
    begin
        state_next      = state_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        prefix_pos_next = prefix_pos_reg;
        suffix_pos_next = suffix_pos_reg;
        mid_done_next   = mid_done_reg;
        count_next      = count_reg;
        fail_next       = fail_reg;
        rd              = '0;
        rd_addr         = '0;
        res_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    char_next  = char_in;
                    last_next  = last_in;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (fail_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (pre_more)
                begin
                    rd.rd_prefix = 1'b1;
                    rd_addr      = prefix_pos_reg[ADDR_W-1:0];
                    state_next   = ST_CMP_P;
                end
                else if (!mid_done_reg && (char_reg == middle_char))
                begin
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_FIN;
                end
                else
                begin
                    mid_done_next = 1'b1;
                    if (!suf_more)
                    begin
                        fail_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rd.rd_suffix = 1'b1;
                        rd_addr      = suffix_pos_reg[ADDR_W-1:0];
                        state_next   = ST_CMP_S;
                    end
                end
            end
            ST_CMP_P:
            begin
                prefix_pos_next = prefix_pos_reg + 1'b1;
                state_next      = cmp_hit ? ST_FIN : ST_WALK;
            end
            ST_CMP_S:
            begin
                suffix_pos_next = suffix_pos_reg + 1'b1;
                state_next      = cmp_hit ? ST_FIN : ST_WALK;
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    // report, then drop the match state for the next word
                    res_load        = 1'b1;
                    prefix_pos_next = '0;
                    suffix_pos_next = '0;
                    mid_done_next   = 1'b0;
                    count_next      = '0;
                    fail_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_reg       <= 1'b0;
            prefix_pos_reg <= '0;
            suffix_pos_reg <= '0;
            mid_done_reg   <= 1'b0;
            count_reg      <= '0;
            fail_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            prefix_pos_reg <= prefix_pos_next;
            suffix_pos_reg <= suffix_pos_next;
            mid_done_reg   <= mid_done_next;
            count_reg      <= count_next;
            fail_reg       <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign count_ext = CNT_EXT_W'(count_reg);
    assign res.matched      = !fail_reg;
    assign res.middle_count = count_ext[RES_COUNT_W-1:0];

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_P) |-> $past(rd.rd_prefix))
        else $error("prefix compare without a prefix read");

    a_fail_after_middle: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg |-> mid_done_reg)
        else $error("word failed before leaving the middle phase");

    a_load_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (state_reg == ST_IDLE) && (count_reg == '0) && !fail_reg)
        else $error("match state not cleared after a result");

endmodule

// File: src/affix_family_subsequence_match.sv
// ----------------------------------------------------------------------------
// affix_family_subsequence_match: streamed word vs prefix.middle*.suffix
// Top level: request decode, configuration registers, tables, result register.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries one request: a
//   prefix or suffix table write, or one character of the word under test.
//   A table write is done when accepted. A word character walks the
//   pattern: each table entry stepped is a table RAM read, then a compare;
//   around these come dispatch, the middle or fail decision and finish. The
//   walk ends on a table hit, a middle repeat or a fail; the registered
//   table read bounds the walk rate. item_stall stays high while a character
//   is walked.
//   result channel (result_valid / result_stall / result) gives one result
//   on the word's last character once its walk ends and the result slot
//   is free. A waiting result does not block new requests; only a second
//   result waits for it.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   middle character and the two table lengths; write it only when idle.
//   Reset clears the registers, the match state and the result valid flag;
//   result data and table contents are undefined until written.
// ----------------------------------------------------------------------------
module affix_family_subsequence_match
    import afsm_pkg::*;
#(
    parameter int AFFIX_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]      cfg_data
);

    localparam int ADDR_W    = (AFFIX_DEPTH > 1) ? $clog2(AFFIX_DEPTH) : 1;
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    logic [CHAR_W-1:0] middle_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [LEN_W-1:0]  slen_reg;

    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic              idx_ok;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_prefix;
    logic              wr_suffix;
    logic              start;
    logic              walk_ready;
    logic              slot_free;
    logic              res_load;
    result_t           res;
    rd_ctrl_t          rd;
    logic [ADDR_W-1:0] rd_addr;
    logic [CHAR_W-1:0] prefix_rdata;
    logic [CHAR_W-1:0] suffix_rdata;

    assign item_stall = !walk_ready;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // drop table writes beyond the table depth
    assign idx_ok    = 32'(item.table_index) < AFFIX_DEPTH;
    assign idx_ext   = IDX_EXT_W'(item.table_index);
    assign wr_addr   = idx_ext[ADDR_W-1:0];
    assign wr_prefix = accept && (item.op == OP_PREFIX) && idx_ok;
    assign wr_suffix = accept && (item.op == OP_SUFFIX) && idx_ok;
    assign start     = accept && (item.op == OP_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            middle_reg <= '0;
            plen_reg   <= '0;
            slen_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIDDLE_CHAR:   middle_reg <= cfg_data;
                CFG_PREFIX_LENGTH: plen_reg   <= cfg_data[LEN_W-1:0];
                CFG_SUFFIX_LENGTH: slen_reg   <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    afsm_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (AFFIX_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (wr_prefix),
        .wr_addr (wr_addr),
        .wr_data (item.char_value),
        .rd_en   (rd.rd_prefix),
        .rd_addr (rd_addr),
        .rd_data (prefix_rdata)
    );

    afsm_ram #(
        .WIDTH  (CHAR_W),
        .DEPTH  (AFFIX_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_suffix_ram (
        .clk     (clk),
        .wr_en   (wr_suffix),
        .wr_addr (wr_addr),
        .wr_data (item.char_value),
        .rd_en   (rd.rd_suffix),
        .rd_addr (rd_addr),
        .rd_data (suffix_rdata)
    );

    afsm_walk #(
        .AFFIX_DEPTH (AFFIX_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .char_in       (item.char_value),
        .last_in       (item.word_last),
        .middle_char   (middle_reg),
        .prefix_length (plen_reg),
        .suffix_length (slen_reg),
        .rd            (rd),
        .rd_addr       (rd_addr),
        .prefix_rdata  (prefix_rdata),
        .suffix_rdata  (suffix_rdata),
        .slot_free     (slot_free),
        .ready         (walk_ready),
        .res_load      (res_load),
        .res           (res)
    );

    // result register: hold while stalled, load when empty or draining
    assign slot_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (res_load)
        begin
            result_valid_next = 1'b1;
            result_next       = res;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_busy_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> item_stall)
        else $error("word character request not held off during its walk");

endmodule
